@@ sv/spq_pkg.sv @@
`default_nettype none

package spq_pkg;

    // default sizes, overridable on the top level
    localparam int CAPACITY_DEF = 16;
    localparam int KEY_BITS_DEF = 16;

    // fixed field widths
    localparam int KEY_PORT_BITS = 16;
    localparam int NAME_BITS     = 64;
    localparam int OCC_BITS      = 5;

    // operation codes carried on kind
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_REMOVE = 1'b1;

    // per-entry data that travels with the key
    typedef struct packed {
        logic [NAME_BITS-1:0] name;
        logic                 tag;
    } payload_t;

    // command broadcast to every cell
    typedef struct packed {
        logic ins;
        logic pop;
    } cell_ctrl_t;

endpackage

`default_nettype wire

@@ sv/sorted_priority_queue_core.sv @@
// Sorted priority queue, stable for equal keys.
// Input channel (in_valid / in_ready) carries one beat per operation: kind
// selects insert (in_key, in_name, in_tag) or remove of the smallest entry.
// Output channel (out_valid / out_ready) returns exactly one beat per input
// beat: done_res, was_empty, was_full, the removed entry (zero on insert or
// on an empty remove) and the occupancy after the operation.
// Entries sit in a row of CAPACITY cells, slot 0 holding the smallest key.
// Each cell compares its key with the incoming one and all cells shift in
// the same cycle, whatever the occupancy. The result is registered and
// its output beat comes in the cycle after the input beat; throughput is
// one beat per cycle while out_ready is high, limited by the single output
// register. When the receiver stalls, the result waits in the output
// register and in_ready stays low until it is taken.
// Reset empties the queue and drops any pending result; no clearing pass.
`default_nettype none

module sorted_priority_queue_core
    import spq_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF,
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire logic                     in_valid,
    output logic                          in_ready,
    input  wire logic                     kind,
    input  wire logic [KEY_PORT_BITS-1:0] in_key,
    input  wire logic [NAME_BITS-1:0]     in_name,
    input  wire logic                     in_tag,
    output logic                          out_valid,
    input  wire logic                     out_ready,
    output logic                          done_res,
    output logic                          was_empty,
    output logic                          was_full,
    output logic [KEY_PORT_BITS-1:0]      out_key,
    output logic [NAME_BITS-1:0]          out_name,
    output logic                          out_tag,
    output logic [OCC_BITS-1:0]           occupancy
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]    cnt_reg;
    logic [CNT_W-1:0]    cnt_next;

    logic                out_valid_reg;
    logic                done_reg;
    logic                empty_reg;
    logic                full_reg;
    logic [KEY_PORT_BITS-1:0] okey_reg;
    logic [NAME_BITS-1:0]     oname_reg;
    logic                     otag_reg;
    logic [OCC_BITS-1:0]      occ_reg;

    logic                accept;
    logic                is_full;
    logic                is_empty;
    cell_ctrl_t          ctrl;

    logic [KEY_PORT_BITS+KEY_BITS-1:0] key_in_ext;
    logic [KEY_BITS-1:0]               new_key;
    payload_t                          new_pay;
    logic [KEY_BITS+KEY_PORT_BITS-1:0] key_out_ext;
    logic [CNT_W+OCC_BITS-1:0]         occ_ext;

    logic [KEY_BITS-1:0] cell_key [CAPACITY];
    payload_t            cell_pay [CAPACITY];
    logic [CAPACITY-1:0] cell_place;
    logic [CAPACITY-1:0] cell_occ;

    // handshake and command decode
    assign accept   = in_valid && in_ready;
    assign in_ready = !out_valid_reg || out_ready;
    assign is_full  = (cnt_reg == CNT_W'(CAPACITY));
    assign is_empty = (cnt_reg == '0);
    assign ctrl.ins = accept && (kind == KIND_INSERT) && !is_full;
    assign ctrl.pop = accept && (kind == KIND_REMOVE) && !is_empty;

    // key taken modulo 2^KEY_BITS
    assign key_in_ext   = {{KEY_BITS{1'b0}}, in_key};
    assign new_key      = key_in_ext[KEY_BITS-1:0];
    assign new_pay.name = in_name;
    assign new_pay.tag  = in_tag;

    // cell chain
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic                prev_place;
        logic [KEY_BITS-1:0] prev_key;
        payload_t            prev_pay;
        logic [KEY_BITS-1:0] next_key;
        payload_t            next_pay;

        assign cell_occ[i] = (CNT_W'(i) < cnt_reg);

        if (i == 0)
        begin : g_first
            assign prev_place = 1'b0;
            assign prev_key   = new_key;
            assign prev_pay   = new_pay;
        end
        else
        begin : g_mid
            assign prev_place = cell_place[i-1];
            assign prev_key   = cell_key[i-1];
            assign prev_pay   = cell_pay[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_key = cell_key[i];
            assign next_pay = cell_pay[i];
        end
        else
        begin : g_inner
            assign next_key = cell_key[i+1];
            assign next_pay = cell_pay[i+1];
        end

        spq_cell #(
            .KEY_BITS (KEY_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .occ        (cell_occ[i]),
            .new_key    (new_key),
            .new_pay    (new_pay),
            .prev_place (prev_place),
            .prev_key   (prev_key),
            .prev_pay   (prev_pay),
            .next_key   (next_key),
            .next_pay   (next_pay),
            .key        (cell_key[i]),
            .pay        (cell_pay[i]),
            .place      (cell_place[i])
        );
    end

    // entry count
    always_comb
    begin
        cnt_next = cnt_reg;
        if (ctrl.ins)
            cnt_next = cnt_reg + 1'b1;
        else if (ctrl.pop)
            cnt_next = cnt_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    // result formatting
    assign key_out_ext = {{KEY_PORT_BITS{1'b0}}, cell_key[0]};
    assign occ_ext     = {{OCC_BITS{1'b0}}, cnt_next};

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (accept)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    // output payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            done_reg  <= ctrl.ins || ctrl.pop;
            empty_reg <= (kind == KIND_REMOVE) && is_empty;
            full_reg  <= (kind == KIND_INSERT) && is_full;
            occ_reg   <= occ_ext[OCC_BITS-1:0];
            if (ctrl.pop)
            begin
                okey_reg  <= key_out_ext[KEY_PORT_BITS-1:0];
                oname_reg <= cell_pay[0].name;
                otag_reg  <= cell_pay[0].tag;
            end
            else
            begin
                okey_reg  <= '0;
                oname_reg <= '0;
                otag_reg  <= 1'b0;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign done_res  = done_reg;
    assign was_empty = empty_reg;
    assign was_full  = full_reg;
    assign out_key   = okey_reg;
    assign out_name  = oname_reg;
    assign out_tag   = otag_reg;
    assign occupancy = occ_reg;

endmodule

`default_nettype wire

@@ sv/spq_cell.sv @@
`default_nettype none

module spq_cell
    import spq_pkg::*;
#(
    parameter int KEY_BITS = KEY_BITS_DEF
)
(
    input  wire logic                clk,
    input  wire cell_ctrl_t          ctrl,
    input  wire logic                occ,
    input  wire logic [KEY_BITS-1:0] new_key,
    input  wire payload_t            new_pay,
    input  wire logic                prev_place,
    input  wire logic [KEY_BITS-1:0] prev_key,
    input  wire payload_t            prev_pay,
    input  wire logic [KEY_BITS-1:0] next_key,
    input  wire payload_t            next_pay,
    output logic [KEY_BITS-1:0]      key,
    output payload_t                 pay,
    output logic                     place
);

    logic [KEY_BITS-1:0] key_reg;
    logic [KEY_BITS-1:0] key_next;
    payload_t            pay_reg;
    payload_t            pay_next;

    // new entry goes here or earlier when this slot is free or strictly larger
    assign place = !occ || (key_reg > new_key);

    // shift right on insert, shift left on pop
    always_comb
    begin
        key_next = key_reg;
        pay_next = pay_reg;
        if (ctrl.ins)
        begin
            if (prev_place)
            begin
                key_next = prev_key;
                pay_next = prev_pay;
            end
            else if (place)
            begin
                key_next = new_key;
                pay_next = new_pay;
            end
        end
        else if (ctrl.pop)
        begin
            key_next = next_key;
            pay_next = next_pay;
        end
    end

    // entry storage
    always_ff @(posedge clk)
    begin
        key_reg <= key_next;
        pay_reg <= pay_next;
    end

    assign key = key_reg;
    assign pay = pay_reg;

endmodule

`default_nettype wire
